[src/channel_baseline_peak_tracker_macros.svh]
// assertion macros shared by the channel baseline peak tracker rtl
`ifndef CHANNEL_BASELINE_PEAK_TRACKER_MACROS_SVH
`define CHANNEL_BASELINE_PEAK_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CBPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CBPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/cbpt_pkg.sv]
// constants and types of the channel baseline peak tracker
`default_nettype none
package cbpt_pkg;
    localparam int CHANNELS    = 32;
    // must be a power of two
    localparam int AVG_DEPTH   = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int AVG_LOG2 = $clog2(AVG_DEPTH);
    localparam int SLOT_W   = AVG_LOG2;
    localparam int CH_W     = 5;
    localparam int CH_AW    = $clog2(CHANNELS);
    localparam int DL_DEPTH = CHANNELS * AVG_DEPTH;
    localparam int DL_AW    = CH_AW + SLOT_W;
    localparam int SUM_W    = SAMPLE_BITS + SLOT_W + 1;
    localparam int NUM_W    = SUM_W + 2;
    localparam int PEAK_W   = SAMPLE_BITS + 1;
    localparam int COST_W   = 18;
    localparam int REC_W    = 16;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 16;

    localparam logic [1:0] MODE_HALT  = 2'd0;
    localparam logic [1:0] MODE_AVG   = 2'd1;
    localparam logic [1:0] MODE_ANA   = 2'd2;
    // unused code, behaves as halt
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_RECORDS = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ACTIVE  = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COST   = 1'b1;
    localparam logic RES_FINISH  = 1'b0;
    localparam logic RES_COST    = 1'b1;

    localparam logic [REC_W-1:0] RECORDS_RESET = 16'd1000;

    // one word of the per-channel memory
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [PEAK_W-1:0]       peak;
    } chan_word_t;
endpackage
`default_nettype wire

[src/cbpt_ram.sv]
// generic single-port-write, registered-read ram
`default_nettype none
module cbpt_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/cbpt_peak_calc.sv]
// magnitude of sample minus baseline, rounded half away from zero
`default_nettype none
module cbpt_peak_calc (
    input  wire logic signed [cbpt_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic signed [cbpt_pkg::SUM_W-1:0]       sum,
    output logic             [cbpt_pkg::PEAK_W-1:0]      mag
);
    logic signed [cbpt_pkg::NUM_W-1:0] num;
    logic        [cbpt_pkg::NUM_W-1:0] num_abs;
    logic        [cbpt_pkg::NUM_W-1:0] quo;
    logic        [cbpt_pkg::AVG_LOG2-1:0] rem;
    logic                              round_up;

    // scaled difference, then divide by the window length with rounding
    always_comb begin
        num = (cbpt_pkg::NUM_W'(sample) <<< cbpt_pkg::AVG_LOG2) - cbpt_pkg::NUM_W'(sum);
        num_abs = num[cbpt_pkg::NUM_W-1] ? cbpt_pkg::NUM_W'(-num) : cbpt_pkg::NUM_W'(num);
        quo = num_abs >> cbpt_pkg::AVG_LOG2;
        rem = num_abs[cbpt_pkg::AVG_LOG2-1:0];
        round_up = (rem >= cbpt_pkg::AVG_LOG2'(cbpt_pkg::AVG_DEPTH / 2));
        mag = quo[cbpt_pkg::PEAK_W-1:0] + cbpt_pkg::PEAK_W'(round_up);
    end
endmodule
`default_nettype wire

[src/channel_baseline_peak_tracker.sv]
// Channel baseline peak tracker. Per-channel delay lines live in a 512x16 ram and
// the running sums and peaks in a 32-entry channel ram; every sample is a read
// followed by a modify-write, so a sample item passes accept, ram read and
// update in turn. The first sample after average mode is entered starts a
// clearing pass over the whole delay-line ram. A cost query scans the channel
// ram one entry a cycle, then hands off its result. Entering analyse mode
// clears the peaks through per-channel valid bits, with no clearing pass. A result
// register sits on the output, so new requests are taken while a result waits.
`default_nettype none
`include "channel_baseline_peak_tracker_macros.svh"
module channel_baseline_peak_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic                          cfg_wr_en,
    input  wire logic [cbpt_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [cbpt_pkg::CFG_DW-1:0]   cfg_data,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // channel[4:0], sample[20:5], zero fill
    input  wire logic        s_tuser,   // kind
    input  wire logic        s_tlast,   // record_end
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // cost[17:0], zero fill
    output logic             m_tuser    // result_kind
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_UPDATE, ST_SCAN, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [1:0] eff_mode_reg, prev_mode_reg;
    logic [cbpt_pkg::REC_W-1:0] records_cfg_reg, records_left_reg;
    logic [cbpt_pkg::CH_W-1:0]  active_reg;
    logic [cbpt_pkg::SLOT_W-1:0] slot_reg;
    logic [cbpt_pkg::DL_AW:0]    clr_cnt_reg;
    logic [cbpt_pkg::CHANNELS-1:0] sum_valid_reg, peak_valid_reg;

    logic [cbpt_pkg::CH_W-1:0]               ch_reg;
    logic signed [cbpt_pkg::SAMPLE_BITS-1:0] smp_reg;
    logic                                    last_reg;

    logic [cbpt_pkg::CH_AW:0]    scan_idx_reg;
    logic                        scan_pend_reg;
    logic [cbpt_pkg::CH_AW-1:0]  scan_ch_reg;
    logic [cbpt_pkg::PEAK_W-1:0] act_peak_reg, hi_peak_reg;

    logic                        res_kind_reg;
    logic [cbpt_pkg::COST_W-1:0] res_cost_reg;
    logic                        m_valid_reg, m_kind_reg;
    logic [cbpt_pkg::COST_W-1:0] m_cost_reg;

    // ram ports
    logic                         dl_we;
    logic [cbpt_pkg::DL_AW-1:0]   dl_waddr, dl_raddr;
    logic [cbpt_pkg::SAMPLE_BITS-1:0] dl_wdata, dl_q;
    logic                         ch_we;
    logic [cbpt_pkg::CH_AW-1:0]   ch_waddr, ch_raddr;
    cbpt_pkg::chan_word_t         ch_wdata, ch_q;

    logic s_acc;
    logic [cbpt_pkg::CH_AW-1:0] chi;
    logic ch_ok;
    logic signed [cbpt_pkg::SUM_W-1:0] sum_old, sum_new;
    logic [cbpt_pkg::PEAK_W-1:0] peak_old, mag, scan_peak;
    logic fin_w;
    logic [cbpt_pkg::REC_W-1:0] rec_dec;

    // assertion terms
    logic clr_w, avg_w, halt_smp_w, fin_nocfg_w, halt_emit_w;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {6'd0, m_cost_reg};

    assign chi   = ch_reg[cbpt_pkg::CH_AW-1:0];
    assign ch_ok = (32'(ch_reg) < cbpt_pkg::CHANNELS);

    cbpt_ram #(.DEPTH(cbpt_pkg::DL_DEPTH), .WIDTH(cbpt_pkg::SAMPLE_BITS)) u_dl_ram (
        .aclk(aclk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .raddr(dl_raddr), .rdata(dl_q)
    );

    cbpt_ram #(.DEPTH(cbpt_pkg::CHANNELS), .WIDTH($bits(cbpt_pkg::chan_word_t))) u_ch_ram (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_q)
    );

    cbpt_peak_calc u_peak (.sample(smp_reg), .sum(sum_old), .mag(mag));

    // read-modify-write datapath
    always_comb begin
        sum_old   = sum_valid_reg[chi] ? ch_q.sum : '0;
        peak_old  = peak_valid_reg[chi] ? ch_q.peak : '0;
        scan_peak = peak_valid_reg[scan_ch_reg] ? ch_q.peak : '0;
        sum_new   = sum_old + cbpt_pkg::SUM_W'(smp_reg)
                  - cbpt_pkg::SUM_W'($signed(dl_q));
        rec_dec   = records_left_reg - 1'b1;
        fin_w     = (state_reg == ST_UPDATE) && (eff_mode_reg == cbpt_pkg::MODE_ANA)
                    && last_reg && (rec_dec == '0);

        dl_raddr = {chi, slot_reg};
        dl_we    = 1'b0;
        dl_waddr = {chi, slot_reg};
        dl_wdata = smp_reg;
        if (state_reg == ST_CLEAR) begin
            dl_we    = 1'b1;
            dl_waddr = clr_cnt_reg[cbpt_pkg::DL_AW-1:0];
            dl_wdata = '0;
        end else if (state_reg == ST_UPDATE && eff_mode_reg == cbpt_pkg::MODE_AVG) begin
            dl_we = ch_ok;
        end

        ch_raddr = (state_reg == ST_SCAN) ? scan_idx_reg[cbpt_pkg::CH_AW-1:0] : chi;
        ch_waddr = chi;
        ch_wdata = ch_q;
        ch_we    = 1'b0;
        if (state_reg == ST_UPDATE && ch_ok) begin
            if (eff_mode_reg == cbpt_pkg::MODE_AVG) begin
                ch_we        = 1'b1;
                ch_wdata.sum = sum_new;
            end else if (eff_mode_reg == cbpt_pkg::MODE_ANA) begin
                ch_we         = 1'b1;
                ch_wdata.peak = (mag > peak_old) ? mag : peak_old;
            end
        end
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            eff_mode_reg     <= cbpt_pkg::MODE_HALT;
            prev_mode_reg    <= cbpt_pkg::MODE_HALT;
            records_cfg_reg  <= cbpt_pkg::RECORDS_RESET;
            records_left_reg <= cbpt_pkg::RECORDS_RESET;
            active_reg       <= '0;
            slot_reg         <= '0;
            clr_cnt_reg      <= '0;
            sum_valid_reg    <= '0;
            peak_valid_reg   <= '0;
            scan_idx_reg     <= '0;
            scan_pend_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    cbpt_pkg::CFG_MODE:    eff_mode_reg    <= cfg_data[1:0];
                    cbpt_pkg::CFG_RECORDS: records_cfg_reg <= cfg_data;
                    cbpt_pkg::CFG_ACTIVE:  active_reg      <= cfg_data[cbpt_pkg::CH_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        ch_reg   <= s_tdata[4:0];
                        smp_reg  <= s_tdata[20:5];
                        last_reg <= s_tlast;
                        if (s_tuser == cbpt_pkg::KIND_COST) begin
                            scan_idx_reg  <= '0;
                            scan_pend_reg <= 1'b0;
                            act_peak_reg  <= '0;
                            hi_peak_reg   <= '0;
                            state_reg     <= ST_SCAN;
                        end else if (eff_mode_reg == cbpt_pkg::MODE_AVG) begin
                            if (prev_mode_reg != cbpt_pkg::MODE_AVG) begin
                                sum_valid_reg <= '0;
                                slot_reg      <= '0;
                                clr_cnt_reg   <= '0;
                                state_reg     <= ST_CLEAR;
                            end else begin
                                state_reg <= ST_READ;
                            end
                        end else if (eff_mode_reg == cbpt_pkg::MODE_ANA) begin
                            if (prev_mode_reg != cbpt_pkg::MODE_ANA) begin
                                peak_valid_reg   <= '0;
                                records_left_reg <= records_cfg_reg;
                            end
                            state_reg <= ST_READ;
                        end else begin
                            prev_mode_reg <= eff_mode_reg;
                        end
                    end
                end
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == cbpt_pkg::DL_DEPTH - 1) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    state_reg     <= fin_w ? ST_EMIT : ST_IDLE;
                    prev_mode_reg <= fin_w ? cbpt_pkg::MODE_HALT : eff_mode_reg;
                    if (eff_mode_reg == cbpt_pkg::MODE_AVG) begin
                        if (ch_ok) begin
                            sum_valid_reg[chi] <= 1'b1;
                        end
                        if (last_reg) begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end else begin
                        if (ch_ok) begin
                            peak_valid_reg[chi] <= 1'b1;
                        end
                        if (last_reg) begin
                            records_left_reg <= rec_dec;
                        end
                        if (fin_w) begin
                            eff_mode_reg <= cbpt_pkg::MODE_HALT;
                            res_kind_reg <= cbpt_pkg::RES_FINISH;
                            res_cost_reg <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    // one channel read a cycle, compared in the next cycle
                    if (32'(scan_idx_reg) < cbpt_pkg::CHANNELS) begin
                        scan_idx_reg  <= scan_idx_reg + 1'b1;
                        scan_ch_reg   <= scan_idx_reg[cbpt_pkg::CH_AW-1:0];
                        scan_pend_reg <= 1'b1;
                    end else begin
                        scan_pend_reg <= 1'b0;
                    end
                    if (scan_pend_reg) begin
                        if (cbpt_pkg::CH_W'(scan_ch_reg) == active_reg) begin
                            act_peak_reg <= scan_peak;
                        end else if (scan_peak > hi_peak_reg) begin
                            hi_peak_reg <= scan_peak;
                        end
                    end else if (32'(scan_idx_reg) == cbpt_pkg::CHANNELS) begin
                        res_kind_reg <= cbpt_pkg::RES_COST;
                        res_cost_reg <= cbpt_pkg::COST_W'(act_peak_reg)
                                      - cbpt_pkg::COST_W'(hi_peak_reg);
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= res_kind_reg;
                        m_cost_reg  <= res_cost_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // short terms for the checks below
    assign clr_w       = (state_reg == ST_CLEAR);
    assign avg_w       = (eff_mode_reg == cbpt_pkg::MODE_AVG);
    assign halt_smp_w  = s_acc && (s_tuser == cbpt_pkg::KIND_SAMPLE) && !cfg_wr_en
                         && (eff_mode_reg != cbpt_pkg::MODE_AVG)
                         && (eff_mode_reg != cbpt_pkg::MODE_ANA);
    assign fin_nocfg_w = fin_w && !cfg_wr_en;
    assign halt_emit_w = (eff_mode_reg == cbpt_pkg::MODE_HALT) && (state_reg == ST_EMIT);

    // the delay-line clearing pass only runs for average mode
    `CBPT_ASSERT_IMPLY(a_clear_avg, aclk, aresetn, clr_w, avg_w)
    // a sample in stop mode leaves the block idle
    `CBPT_ASSERT_NEXT(a_stop_idle, aclk, aresetn, halt_smp_w, state_reg == ST_IDLE)
    // the last analyse record stops the block and emits a result
    `CBPT_ASSERT_NEXT(a_finish_stop, aclk, aresetn, fin_nocfg_w, halt_emit_w)
endmodule
`default_nettype wire

[test/tb_top.sv]
// self-checking testbench of the channel baseline peak tracker
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    // clearing pass of the delay-line ram plus cost scan, with margin
    localparam int SETTLE_CYCLES = 700;

    typedef struct {
        logic        kind;
        logic [17:0] cost;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [cbpt_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [cbpt_pkg::CFG_DW-1:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    channel_baseline_peak_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    logic signed [15:0] pred_delay [cbpt_pkg::CHANNELS][cbpt_pkg::AVG_DEPTH];
    int                 pred_sum [cbpt_pkg::CHANNELS];
    int                 pred_slot;
    int                 pred_peak [cbpt_pkg::CHANNELS];
    logic [15:0]        pred_left;
    logic [1:0]         pred_mode;
    logic [1:0]         pred_prev_mode;
    logic [15:0]        pred_records;
    logic [4:0]         pred_active;

    result_t expected_results[$];
    int      fail_count = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;      // no idling on either side
    int      hold_request = 0;  // long receiver hold-off, in cycles

    // |round(num / AVG_DEPTH)|, half away from zero
    function automatic int round_mag(int num);
        int a;
        int q;
        a = (num < 0) ? -num : num;
        q = a / cbpt_pkg::AVG_DEPTH;
        if (2 * (a % cbpt_pkg::AVG_DEPTH) >= cbpt_pkg::AVG_DEPTH) q++;
        return q;
    endfunction

    function automatic void tracker_predict(logic kind, logic [4:0] ch,
                                            logic signed [15:0] s, logic last);
        int highest;
        int act;
        int mag;
        result_t r;
        highest = 0;
        act = 0;
        if (kind == cbpt_pkg::KIND_COST) begin
            for (int c = 0; c < cbpt_pkg::CHANNELS; c++) begin
                if (c == pred_active) act = pred_peak[c];
                else if (pred_peak[c] > highest) highest = pred_peak[c];
            end
            r.kind = cbpt_pkg::RES_COST;
            r.cost = 18'(act - highest);
            expected_results.push_back(r);
            return;
        end
        if (pred_mode == cbpt_pkg::MODE_AVG) begin
            // entering average clears the baseline stores
            if (pred_prev_mode != cbpt_pkg::MODE_AVG) begin
                for (int c = 0; c < cbpt_pkg::CHANNELS; c++) begin
                    pred_sum[c] = 0;
                    for (int k = 0; k < cbpt_pkg::AVG_DEPTH; k++) pred_delay[c][k] = '0;
                end
                pred_slot = 0;
            end
            pred_sum[ch] += int'(s) - int'(pred_delay[ch][pred_slot]);
            pred_delay[ch][pred_slot] = s;
            if (last) pred_slot = (pred_slot + 1) % cbpt_pkg::AVG_DEPTH;
        end else if (pred_mode == cbpt_pkg::MODE_ANA) begin
            if (pred_prev_mode != cbpt_pkg::MODE_ANA) begin
                for (int c = 0; c < cbpt_pkg::CHANNELS; c++) pred_peak[c] = 0;
                pred_left = pred_records;
            end
            mag = round_mag(int'(s) * cbpt_pkg::AVG_DEPTH - pred_sum[ch]);
            if (mag > pred_peak[ch]) pred_peak[ch] = mag;
            if (last) begin
                pred_left = pred_left - 16'd1;
                if (pred_left == 16'd0) begin
                    pred_mode = cbpt_pkg::MODE_HALT;
                    r.kind = cbpt_pkg::RES_FINISH;
                    r.cost = '0;
                    expected_results.push_back(r);
                end
            end
        end
        pred_prev_mode = pred_mode;
    endfunction

    // timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d data %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (m_tuser !== e.kind) begin
                    $error("result_kind expected %0d actual %0d", e.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata !== {6'd0, e.cost}) begin
                    $error("cost expected %h actual %h", {6'd0, e.cost}, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts and requested long hold-offs
    int hold_left = 0;
    int stall_left = 0;
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // offer one request and wait for its acceptance
    task automatic send_item(logic kind, logic [4:0] ch, logic signed [15:0] s,
                             logic last);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tlast = last;
        s_tdata = {3'd0, s, ch};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        tracker_predict(kind, ch, s, last);
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // register write once the block has finished all work
    task automatic write_reg(logic [cbpt_pkg::CFG_IW-1:0] idx,
                             logic [cbpt_pkg::CFG_DW-1:0] value);
        go_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge aclk);
        if (idx == cbpt_pkg::CFG_MODE) pred_mode = value[1:0];
        else if (idx == cbpt_pkg::CFG_RECORDS) pred_records = value;
        else if (idx == cbpt_pkg::CFG_ACTIVE) pred_active = value[4:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_random_sample(int end_odds);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'($urandom_range(0, 31)), 16'($urandom),
                  $urandom_range(0, end_odds - 1) == 0);
    endtask

    // stop mode at reset: samples do nothing, cost is zero
    task automatic test_reset_state();
        send_item(cbpt_pkg::KIND_COST, 5'd0, 16'sd0, 1'b0);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd3, 16'sh7fff, 1'b1);
        send_item(cbpt_pkg::KIND_COST, 5'd31, -16'sd1, 1'b1);
    endtask

    // sample extremes, both modes, finish, cost sign, mode three, mode rewrite
    task automatic test_directed();
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_AVG));
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd0, 16'sh7fff, 1'b0);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd31, -16'sd32768, 1'b1);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd0, -16'sd32768, 1'b1);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd5, 16'sd8, 1'b1);
        write_reg(cbpt_pkg::CFG_RECORDS, 16'd2);
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_ANA));
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd0, -16'sd32768, 1'b0);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd31, 16'sh7fff, 1'b0);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd5, 16'sd1, 1'b0);
        send_item(cbpt_pkg::KIND_COST, 5'd0, 16'sd0, 1'b0);
        write_reg(cbpt_pkg::CFG_ACTIVE, 16'd31);
        send_item(cbpt_pkg::KIND_COST, 5'd0, 16'sd0, 1'b0);
        write_reg(cbpt_pkg::CFG_ACTIVE, 16'd5);
        send_item(cbpt_pkg::KIND_COST, 5'd0, 16'sd0, 1'b0);
        // rewriting the current mode keeps the peaks
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_ANA));
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd5, 16'sd2, 1'b1);
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd6, 16'sd3, 1'b1);
        // mode three behaves as stop
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_SPARE));
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd7, 16'sh7fff, 1'b1);
        send_item(cbpt_pkg::KIND_COST, 5'd0, 16'sd0, 1'b0);
        // zero and largest record counts, not run to completion
        write_reg(cbpt_pkg::CFG_RECORDS, 16'd0);
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_ANA));
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd9, 16'sh4000, 1'b1);
        write_reg(cbpt_pkg::CFG_RECORDS, 16'hffff);
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_HALT));
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_ANA));
        send_item(cbpt_pkg::KIND_SAMPLE, 5'd9, -16'sd5, 1'b1);
        send_item(cbpt_pkg::KIND_COST, 5'd0, 16'sd0, 1'b0);
    endtask

    // fill the result register while the receiver holds off, then drain
    task automatic test_backpressure();
        hold_request = 400;
        for (int i = 0; i < 8; i++) begin
            send_item(cbpt_pkg::KIND_COST, 5'($urandom), 16'($urandom), 1'b0);
        end
        for (int i = 0; i < 6; i++) send_random_sample(4);
        go_idle();
        wait_drained();
        for (int i = 0; i < 4; i++) send_random_sample(4);
    endtask

    // baseline phase then analyse phase, run until it finishes or the item guard runs out, with queries mixed in
    task automatic random_round(int n_avg);
        int guard;
        write_reg(cbpt_pkg::CFG_ACTIVE, 16'($urandom));
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_AVG));
        for (int i = 0; i < n_avg; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(cbpt_pkg::KIND_COST, 5'($urandom), 16'($urandom), 1'b0);
            end else begin
                send_random_sample(3);
            end
        end
        write_reg(cbpt_pkg::CFG_RECORDS, ($urandom_range(0, 9) == 0)
                                         ? 16'($urandom | 16'h8000)
                                         : 16'($urandom_range(1, 8)));
        write_reg(cbpt_pkg::CFG_MODE, 16'(cbpt_pkg::MODE_ANA));
        guard = 0;
        while (pred_mode == cbpt_pkg::MODE_ANA && guard < 80) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(cbpt_pkg::KIND_COST, 5'($urandom), 16'($urandom), 1'b0);
            end else begin
                send_random_sample(4);
            end
            guard++;
        end
        // noise: samples, half the time after a switch to stop or mode three, then a query
        if ($urandom_range(0, 1) == 0) begin
            write_reg(cbpt_pkg::CFG_MODE,
                      16'($urandom_range(0, 1) ? cbpt_pkg::MODE_SPARE
                                               : cbpt_pkg::MODE_HALT));
        end
        for (int i = 0; i < 3; i++) send_random_sample(2);
        send_item(cbpt_pkg::KIND_COST, 5'($urandom), 16'($urandom), 1'b1);
    endtask

    task automatic test_random();
        for (int r = 0; r < 16; r++) random_round($urandom_range(10, 40));
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        for (int r = 0; r < 3; r++) random_round(30);
    endtask

    initial begin
        pred_slot = 0;
        pred_left = cbpt_pkg::RECORDS_RESET;
        pred_records = cbpt_pkg::RECORDS_RESET;
        pred_active = '0;
        pred_mode = cbpt_pkg::MODE_HALT;
        pred_prev_mode = cbpt_pkg::MODE_HALT;
        for (int c = 0; c < cbpt_pkg::CHANNELS; c++) begin
            pred_sum[c] = 0;
            pred_peak[c] = 0;
            for (int k = 0; k < cbpt_pkg::AVG_DEPTH; k++) pred_delay[c][k] = '0;
        end
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        test_reset_state();
        test_directed();
        test_backpressure();
        test_random();
        test_no_idle();
        go_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
